// ----- rtl/rational_normalize_reduce_defines.svh -----
// Assertion macros shared by the rational reduction RTL.
`ifndef RATIONAL_NORMALIZE_REDUCE_DEFINES_SVH
`define RATIONAL_NORMALIZE_REDUCE_DEFINES_SVH

`ifndef SYNTHESIS
`define RNR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rnr assertion failed");
`define RNR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rnr assertion failed");
`else
`define RNR_ASSERT_IMP(lbl, ante, cons)
`define RNR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/rnr_pkg.sv -----
// Shared types and operation codes for the rational reduction block.
package rnr_pkg;

    typedef logic op_t;

    localparam op_t OP_SUB = 1'b0;
    localparam op_t OP_ABS = 1'b1;

endpackage

// ----- rtl/rnr_sub_unit.sv -----
// Shared subtract unit: difference or absolute difference with borrow.
module rnr_sub_unit #(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0] x,
    input  logic [WIDTH-1:0] y,
    input  rnr_pkg::op_t     op,
    output logic [WIDTH-1:0] res,
    output logic             borrow
);
    import rnr_pkg::*;

    logic [WIDTH:0] diff;

    assign diff   = {1'b0, x} - {1'b0, y};
    assign borrow = diff[WIDTH];

    always_comb
    begin
        if (op == OP_ABS && borrow)
        begin
            res = ~diff[WIDTH-1:0] + {{(WIDTH-1){1'b0}}, 1'b1};
        end
        else
        begin
            res = diff[WIDTH-1:0];
        end
    end

endmodule

// ----- rtl/rational_normalize_reduce.sv -----
// Top level: reduces a signed fraction to lowest terms with a positive denominator.
// Steps: a binary GCD, two restoring divisions by the GCD (numerator, then denominator),
// then loading the output registers. A zero denominator goes straight to the output load.
// A new fraction is taken only in idle; the single shared subtractor serves the GCD and
// both divisions. A stalled result holds the sequencer in its last step.
// Reset clears the sequencer and the output valid; data registers are not reset.
`include "rational_normalize_reduce_defines.svh"

module rational_normalize_reduce #(
    parameter int WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [WIDTH-1:0] num_in,
    input  logic signed [WIDTH-1:0] den_in,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [WIDTH-1:0] num_out,
    output logic        [WIDTH-2:0] den_out,
    output logic                    zero_den_error
);
    import rnr_pkg::*;

    localparam int CW = $clog2(WIDTH);
    localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GCD  = 3'd1;
    localparam logic [2:0] ST_DIVN = 3'd2;
    localparam logic [2:0] ST_DIVD = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [CW-1:0]    k_reg, k_next;
    logic [WIDTH-1:0] g_reg, g_next;
    logic [WIDTH-1:0] nmag_reg, nmag_next;
    logic [WIDTH-1:0] dmag_reg, dmag_next;
    logic [WIDTH-1:0] q_reg, q_next;
    logic [WIDTH-1:0] r_reg, r_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic             err_reg, err_next;
    logic [WIDTH-2:0] rn_reg, rn_next;
    logic [WIDTH-2:0] rd_reg, rd_next;
    logic [WIDTH-1:0] num_out_reg, num_out_next;
    logic [WIDTH-2:0] den_out_reg, den_out_next;
    logic             zde_reg, zde_next;
    logic             out_valid_reg, out_valid_next;

    logic [WIDTH-1:0] num_mag, den_mag;
    logic [WIDTH-1:0] unit_x, unit_y, unit_res;
    op_t              unit_op;
    logic             unit_borrow;
    logic [WIDTH-1:0] rem_shift;
    logic [WIDTH-1:0] q_step;
    logic [WIDTH-1:0] r_step;
    logic [WIDTH-2:0] q_sat;
    logic [WIDTH-1:0] rn_ext;

    assign num_mag = num_in[WIDTH-1] ? (~num_in + WIDTH'(1)) : num_in;
    assign den_mag = den_in[WIDTH-1] ? (~den_in + WIDTH'(1)) : den_in;

    assign rem_shift = {r_reg[WIDTH-2:0], q_reg[WIDTH-1]};

    always_comb
    begin
        if (state_reg == ST_GCD)
        begin
            unit_op = OP_ABS;
            unit_x  = a_reg;
            unit_y  = b_reg;
        end
        else
        begin
            unit_op = OP_SUB;
            unit_x  = rem_shift;
            unit_y  = g_reg;
        end
    end

    rnr_sub_unit #(
        .WIDTH (WIDTH)
    ) u_sub (
        .x      (unit_x),
        .y      (unit_y),
        .op     (unit_op),
        .res    (unit_res),
        .borrow (unit_borrow)
    );

    assign q_step = {q_reg[WIDTH-2:0], ~unit_borrow};
    assign r_step = unit_borrow ? rem_shift : unit_res;
    assign q_sat  = q_step[WIDTH-1] ? {(WIDTH-1){1'b1}} : q_step[WIDTH-2:0];
    assign rn_ext = {1'b0, rn_reg};

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        k_next         = k_reg;
        g_next         = g_reg;
        nmag_next      = nmag_reg;
        dmag_next      = dmag_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        err_next       = err_reg;
        rn_next        = rn_reg;
        rd_next        = rd_reg;
        num_out_next   = num_out_reg;
        den_out_next   = den_out_reg;
        zde_next       = zde_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    a_next    = num_mag;
                    b_next    = den_mag;
                    nmag_next = num_mag;
                    dmag_next = den_mag;
                    k_next    = '0;
                    neg_next  = num_in[WIDTH-1] ^ den_in[WIDTH-1];
                    err_next  = (den_mag == '0);
                    rn_next   = '0;
                    rd_next   = {{(WIDTH-2){1'b0}}, 1'b1};
                    state_next = (den_mag == '0) ? ST_DONE : ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (a_reg == b_reg || a_reg == '0)
                begin
                    g_next     = b_reg << k_reg;
                    q_next     = nmag_reg;
                    r_next     = '0;
                    cnt_next   = CNT_LAST;
                    state_next = ST_DIVN;
                end
                else if (!a_reg[0] && !b_reg[0])
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + CW'(1);
                end
                else if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                end
                else if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else if (unit_borrow)
                begin
                    b_next = unit_res >> 1;
                end
                else
                begin
                    a_next = unit_res >> 1;
                end
            end
            ST_DIVN:
            begin
                q_next = q_step;
                r_next = r_step;
                if (cnt_reg == '0)
                begin
                    rn_next    = q_sat;
                    q_next     = dmag_reg;
                    r_next     = '0;
                    cnt_next   = CNT_LAST;
                    state_next = ST_DIVD;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            ST_DIVD:
            begin
                q_next = q_step;
                r_next = r_step;
                if (cnt_reg == '0)
                begin
                    rd_next    = q_sat;
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    num_out_next   = neg_reg ? (~rn_ext + WIDTH'(1)) : rn_ext;
                    den_out_next   = rd_reg;
                    zde_next       = err_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        k_reg       <= k_next;
        g_reg       <= g_next;
        nmag_reg    <= nmag_next;
        dmag_reg    <= dmag_next;
        q_reg       <= q_next;
        r_reg       <= r_next;
        cnt_reg     <= cnt_next;
        neg_reg     <= neg_next;
        err_reg     <= err_next;
        rn_reg      <= rn_next;
        rd_reg      <= rd_next;
        num_out_reg <= num_out_next;
        den_out_reg <= den_out_next;
        zde_reg     <= zde_next;
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign num_out        = num_out_reg;
    assign den_out        = den_out_reg;
    assign zero_den_error = zde_reg;

    `RNR_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready)
    `RNR_ASSERT_IMP(a_den_nonzero, out_valid, den_out != '0)
    `RNR_ASSERT_IMP(a_err_zero_one, out_valid && zero_den_error, num_out == '0 && den_out == 1)
    `RNR_ASSERT_IMP(a_divisor_nonzero, state_reg == ST_DIVN || state_reg == ST_DIVD, g_reg != '0)

endmodule
